>>> hdl/ugfe_pkg.sv
// Shared types, constants and byte functions of the gateway frame encoder.
package ugfe_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned STEP_W = 4;
	localparam int unsigned DEF_QUEUE_DEPTH = 4;

	localparam logic [PADDR_W-1:0] ADDR_EXT_HDR = PADDR_W'(0);

	localparam logic [7:0] LFSR_SEED = 8'h42;
	localparam logic [7:0] LFSR_TAPS = 8'hB8;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0] ESC_BYTE = 8'h7D;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ACK_BASE = 8'h80;
	localparam logic [7:0] RST_B0 = 8'h1A;
	localparam logic [7:0] RST_B1 = 8'hC0;
	localparam logic [7:0] RST_B2 = 8'h38;
	localparam logic [7:0] RST_B3 = 8'hBC;
	localparam logic [7:0] HDR_ONES = 8'hFF;
	localparam logic [7:0] HDR_ZERO = 8'h00;

	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,
		CMD_ACK  = 2'd1,
		CMD_RST  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// what the back end does with one queued byte
	typedef enum logic [2:0] {
		OP_RAW,     // send as is
		OP_STUFF,   // send escaped
		OP_HDR,     // restart crc/lfsr, crc over raw byte, send escaped
		OP_WHT,     // whiten, crc, send escaped
		OP_CRC_HI,  // send escaped crc high byte
		OP_CRC_LO   // send escaped crc low byte
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] value;
		logic       last;
	} op_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] x;
		x = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
		end
		return x;
	endfunction

	function automatic logic [7:0] lfsr_next(input logic [7:0] r);
		return {1'b0, r[7:1]} ^ (r[0] ? LFSR_TAPS : 8'h00);
	endfunction

	function automatic logic needs_escape(input logic [7:0] b);
		return b inside {8'h11, 8'h13, 8'h18, 8'h1A, 8'h7D, 8'h7E};
	endfunction

endpackage

>>> hdl/ugfe_in_if.sv
// Command channel: command, payload byte and frame-close mark.
interface ugfe_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, cmd, data_byte, last_byte, input ready);
	modport sink (input valid, cmd, data_byte, last_byte, output ready);
endinterface

>>> hdl/ugfe_out_if.sv
// Line channel: one serial line byte per word.
interface ugfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, out_byte, run_end, input ready);
	modport sink (input valid, out_byte, run_end, output ready);
endinterface

>>> hdl/ugfe_front.sv
// Front end: takes command words, tracks frame state, lists the byte ops.
module ugfe_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ext_hdr,
	ugfe_in_if.sink         req,
	output ugfe_pkg::op_t   push_op,
	output logic            push,
	input  logic            full
);

	logic                           busy_q;
	logic [ugfe_pkg::STEP_W-1:0]    step_q;
	ugfe_pkg::cmd_t                 cmd_q;
	logic [7:0]                     data_q;
	logic                           last_q;
	logic                           hdr_q;
	logic                           ext_q;
	logic [7:0]                     seq_q;
	logic [2:0]                     ack_snap_q;

	logic [7:0]                     frame_seq_q;
	logic [2:0]                     ack_num_q;
	logic                           in_frame_q;

	ugfe_pkg::cmd_t                 cmd_in;
	logic                           accept;
	logic                           op_final;
	logic [ugfe_pkg::STEP_W-1:0]    hlen;
	logic [ugfe_pkg::STEP_W-1:0]    t;
	logic [7:0]                     data_ctrl;
	logic [7:0]                     ack_ctrl;
	logic [15:0]                    ack_crc;

	assign cmd_in = ugfe_pkg::cmd_t'(req.cmd);
	assign push = busy_q && !full;
	assign req.ready = !busy_q || (push && op_final);
	assign accept = req.valid && req.ready;

	assign data_ctrl = {1'b0, seq_q[2:0], 1'b0, ack_snap_q};
	assign ack_ctrl = ugfe_pkg::ACK_BASE | {5'd0, ack_snap_q};
	assign ack_crc = ugfe_pkg::crc_update(ugfe_pkg::CRC_INIT, ack_ctrl);

	always_comb begin
		hlen = hdr_q ? (ext_q ? ugfe_pkg::STEP_W'(5) : ugfe_pkg::STEP_W'(3)) : '0;
		t = step_q - hlen;
		push_op = '{kind: ugfe_pkg::OP_RAW, value: ugfe_pkg::FLAG_BYTE, last: 1'b1};
		op_final = 1'b0;
		case (cmd_q)
			ugfe_pkg::CMD_DATA: begin
				if (step_q < hlen) begin
					push_op.last = 1'b0;
					case (step_q)
						ugfe_pkg::STEP_W'(0): begin
							push_op.kind = ugfe_pkg::OP_HDR;
							push_op.value = data_ctrl;
						end
						ugfe_pkg::STEP_W'(1): begin
							push_op.kind = ugfe_pkg::OP_WHT;
							push_op.value = seq_q;
						end
						ugfe_pkg::STEP_W'(3): begin
							push_op.kind = ugfe_pkg::OP_WHT;
							push_op.value = ugfe_pkg::HDR_ONES;
						end
						default: begin
							push_op.kind = ugfe_pkg::OP_WHT;
							push_op.value = ugfe_pkg::HDR_ZERO;
						end
					endcase
				end else begin
					case (t)
						ugfe_pkg::STEP_W'(0): begin
							push_op.kind = ugfe_pkg::OP_WHT;
							push_op.value = data_q;
							push_op.last = !last_q;
							op_final = !last_q;
						end
						ugfe_pkg::STEP_W'(1): begin
							push_op.kind = ugfe_pkg::OP_CRC_HI;
							push_op.last = 1'b0;
						end
						ugfe_pkg::STEP_W'(2): begin
							push_op.kind = ugfe_pkg::OP_CRC_LO;
							push_op.last = 1'b0;
						end
						default: op_final = 1'b1;
					endcase
				end
			end
			ugfe_pkg::CMD_ACK: begin
				push_op.last = 1'b0;
				case (step_q)
					ugfe_pkg::STEP_W'(0): push_op.value = ack_ctrl;
					ugfe_pkg::STEP_W'(1): begin
						push_op.kind = ugfe_pkg::OP_STUFF;
						push_op.value = ack_crc[15:8];
					end
					ugfe_pkg::STEP_W'(2): begin
						push_op.kind = ugfe_pkg::OP_STUFF;
						push_op.value = ack_crc[7:0];
					end
					default: begin
						push_op.last = 1'b1;
						op_final = 1'b1;
					end
				endcase
			end
			ugfe_pkg::CMD_RST: begin
				push_op.last = 1'b0;
				case (step_q)
					ugfe_pkg::STEP_W'(0): push_op.value = ugfe_pkg::RST_B0;
					ugfe_pkg::STEP_W'(1): push_op.value = ugfe_pkg::RST_B1;
					ugfe_pkg::STEP_W'(2): push_op.value = ugfe_pkg::RST_B2;
					ugfe_pkg::STEP_W'(3): push_op.value = ugfe_pkg::RST_B3;
					default: begin
						push_op.last = 1'b1;
						op_final = 1'b1;
					end
				endcase
			end
			default: op_final = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			cmd_q <= ugfe_pkg::CMD_NONE;
			frame_seq_q <= '0;
			ack_num_q <= '0;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			busy_q <= (cmd_in != ugfe_pkg::CMD_NONE);
			step_q <= '0;
			cmd_q <= cmd_in;
			case (cmd_in)
				ugfe_pkg::CMD_DATA: begin
					in_frame_q <= !req.last_byte;
					if (req.last_byte) begin
						frame_seq_q <= frame_seq_q + 8'd1;
					end
				end
				ugfe_pkg::CMD_ACK: ack_num_q <= ack_num_q + 3'd1;
				ugfe_pkg::CMD_RST: begin
					frame_seq_q <= '0;
					ack_num_q <= '0;
					in_frame_q <= 1'b0;
				end
				default: ;
			endcase
		end else if (push) begin
			step_q <= step_q + ugfe_pkg::STEP_W'(1);
			if (op_final) begin
				busy_q <= 1'b0;
			end
		end
	end

	// item payload, held for the op listing
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.data_byte;
			last_q <= req.last_byte;
			hdr_q <= !in_frame_q;
			ext_q <= ext_hdr;
			seq_q <= frame_seq_q;
			ack_snap_q <= (cmd_in == ugfe_pkg::CMD_ACK) ? ack_num_q + 3'd1 : ack_num_q;
		end
	end

	a_rst_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_in == ugfe_pkg::CMD_RST)
		|=> (!in_frame_q && frame_seq_q == '0 && ack_num_q == '0))
		else $error("reset frame did not clear sequence state");

endmodule

>>> hdl/ugfe_fifo.sv
// Op queue between front and back end.
module ugfe_fifo #(
	parameter int unsigned DEPTH = ugfe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ugfe_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output ugfe_pkg::op_t head_op,
	output logic          head_valid
);

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	ugfe_pkg::op_t   mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)) && count_q <= CntW'(DEPTH))
		else $error("op queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("op queue popped while empty");

endmodule

>>> hdl/ugfe_back.sv
// Back end: whitening, CRC and escaping of queued ops onto the line.
module ugfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ugfe_pkg::op_t  head_op,
	input  logic           head_valid,
	output logic           pop,
	ugfe_out_if.source     tx
);

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_end_q;
	logic        esc_pending_q;
	logic [7:0]  esc_byte_q;
	logic        esc_end_q;
	logic [15:0] crc_q;
	logic [7:0]  wht_q;

	logic        can_load;
	logic [7:0]  line_b;
	logic        stuff;
	logic        esc;
	logic [7:0]  whitened;
	logic [15:0] crc_n;
	logic [7:0]  wht_n;

	assign can_load = !out_valid_q || tx.ready;
	assign pop = can_load && !esc_pending_q && head_valid;

	assign tx.valid = out_valid_q;
	assign tx.out_byte = out_byte_q;
	assign tx.run_end = out_end_q;

	always_comb begin
		whitened = head_op.value ^ wht_q;
		line_b = head_op.value;
		stuff = 1'b1;
		crc_n = crc_q;
		wht_n = wht_q;
		case (head_op.kind)
			ugfe_pkg::OP_RAW: stuff = 1'b0;
			ugfe_pkg::OP_STUFF: ;
			ugfe_pkg::OP_HDR: begin
				crc_n = ugfe_pkg::crc_update(ugfe_pkg::CRC_INIT, head_op.value);
				wht_n = ugfe_pkg::LFSR_SEED;
			end
			ugfe_pkg::OP_WHT: begin
				line_b = whitened;
				crc_n = ugfe_pkg::crc_update(crc_q, whitened);
				wht_n = ugfe_pkg::lfsr_next(wht_q);
			end
			ugfe_pkg::OP_CRC_HI: line_b = crc_q[15:8];
			ugfe_pkg::OP_CRC_LO: line_b = crc_q[7:0];
			default: stuff = 1'b0;
		endcase
		esc = stuff && ugfe_pkg::needs_escape(line_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			esc_pending_q <= 1'b0;
			crc_q <= ugfe_pkg::CRC_INIT;
			wht_q <= ugfe_pkg::LFSR_SEED;
		end else if (can_load) begin
			if (esc_pending_q) begin
				out_valid_q <= 1'b1;
				esc_pending_q <= 1'b0;
			end else if (head_valid) begin
				out_valid_q <= 1'b1;
				esc_pending_q <= esc;
				crc_q <= crc_n;
				wht_q <= wht_n;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (esc_pending_q) begin
				out_byte_q <= esc_byte_q;
				out_end_q <= esc_end_q;
			end else if (head_valid) begin
				out_byte_q <= esc ? ugfe_pkg::ESC_BYTE : line_b;
				out_end_q <= head_op.last && !esc;
				esc_byte_q <= line_b ^ ugfe_pkg::ESC_XOR;
				esc_end_q <= head_op.last;
			end
		end
	end

	a_esc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		esc_pending_q |-> (out_valid_q && out_byte_q == ugfe_pkg::ESC_BYTE && !out_end_q))
		else $error("escaped byte pending without escape mark on the line");

endmodule

>>> hdl/uart_gateway_frame_encoder_unit.sv
// Top level of the gateway transmit framer: config register, front, op queue, back.
// Path of a command: front command registers, op queue, line output register.
// Throughput: one line word per cycle while tx.ready holds; a mid-frame payload byte is one op
//   and one or two line words (two when escaped).
// Opening a frame adds 3 or 5 header ops, closing adds 3 trailer ops; ACK 4 ops, RST 5.
// Reset (arst_n, async): frame state, CRC 0xFFFF, LFSR 0x42, queue empty, ext header off.
module uart_gateway_frame_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = ugfe_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ugfe_in_if.sink                       req,
	ugfe_out_if.source                    tx,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ugfe_pkg::PADDR_W-1:0]  paddr,
	input  logic [ugfe_pkg::DATA_W-1:0]   pwdata,
	output logic [ugfe_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// extended header enable, the only register
	logic          ext_hdr_q;
	logic          cfg_wr;
	logic          ext_sel;

	// front to queue
	ugfe_pkg::op_t push_op;
	logic          push;
	logic          full;

	// queue to back
	ugfe_pkg::op_t head_op;
	logic          head_valid;
	logic          pop;

	assign pready = 1'b1;
	assign ext_sel = ({paddr[ugfe_pkg::PADDR_W-1:2], 2'b00} == ugfe_pkg::ADDR_EXT_HDR);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = ext_sel ? {{(ugfe_pkg::DATA_W-1){1'b0}}, ext_hdr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_hdr_q <= 1'b0;
		end else if (cfg_wr && ext_sel) begin
			ext_hdr_q <= pwdata[0];
		end
	end

	// front: classify commands, expand each into byte ops
	ugfe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.ext_hdr (ext_hdr_q),
		.req     (req),
		.push_op (push_op),
		.push    (push),
		.full    (full)
	);

	// short queue absorbs line-side stalls until it fills, then holds up command intake
	ugfe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (full),
		.pop        (pop),
		.head_op    (head_op),
		.head_valid (head_valid)
	);

	// back: whiten, CRC, escape, drive the line register
	ugfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.head_valid (head_valid),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

>>> tb/sv/tb_uart_gateway_frame_encoder_unit.sv
// Testbench of the gateway transmit framer: directed table, random frames, line word checks.
module tb_uart_gateway_frame_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Line coding constants, kept local so the prediction does not lean on the package.
	localparam logic [15:0] CCITT_POLY = 16'h1021;
	localparam logic [15:0] CCITT_SEED = 16'hFFFF;
	localparam logic [7:0]  WHITE_SEED = 8'h42;
	localparam logic [7:0]  WHITE_TAPS = 8'hB8;
	localparam logic [7:0]  ESC_MARK   = 8'h7D;
	localparam logic [7:0]  ESC_FLIP   = 8'h20;
	localparam logic [7:0]  LINE_FLAG  = 8'h7E;
	localparam logic [7:0]  ACK_CTRL   = 8'h80;
	localparam logic [39:0] RST_LINE   = 40'h1A_C0_38_BC_7E;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_TAIL   = 16;
	localparam int PHASE_ITEMS = 105;  // four random phases, about 420 commands

	// One line word as it should appear on tx.
	typedef struct packed {
		logic [7:0] val;
		logic       fin;
	} line_word_t;

	// One row of the directed table. Rows with typed_in set carry their line bytes
	// (first byte in the top octet); all others are checked against the predictor.
	typedef struct packed {
		ugfe_pkg::cmd_t cmd;
		logic [7:0]     data;
		logic           fin;
		logic           ext;
		logic           typed_in;
		logic [2:0]     n_typed;
		logic [39:0]    typed_bytes;
	} dir_row_t;

	localparam int N_DIRECTED = 22;
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// short header mode
		// one-byte frame, seq 0, ack 0
		'{ugfe_pkg::CMD_DATA, 8'h00, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
		// payload whitens to the flag: escaped
		'{ugfe_pkg::CMD_DATA, 8'hD6, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 40'h0}, // opens a frame
		// ack inside an open frame
		'{ugfe_pkg::CMD_ACK,  8'h5A, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
		// frame carries on after the ack
		'{ugfe_pkg::CMD_DATA, 8'h80, 1'b0, 1'b0, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_DATA, 8'h7D, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0}, // close: crc and flag
		// undefined command: no line words
		'{ugfe_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b0, 1'b1, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_ACK,  8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 40'h0},
		// control byte with seq 3, ack 2
		'{ugfe_pkg::CMD_DATA, 8'h01, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
		// fixed reset frame
		'{ugfe_pkg::CMD_RST,  8'hA5, 1'b1, 1'b0, 1'b1, 3'd5, RST_LINE},
		// ack number restarted by the reset
		'{ugfe_pkg::CMD_ACK,  8'hFF, 1'b1, 1'b0, 1'b0, 3'd0, 40'h0},
		// extended header mode
		'{ugfe_pkg::CMD_DATA, 8'h00, 1'b1, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_DATA, 8'hFF, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_DATA, 8'h55, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_ACK,  8'h00, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_DATA, 8'hAA, 1'b1, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_DATA, 8'h12, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0},
		// reset drops the open frame
		'{ugfe_pkg::CMD_RST,  8'h00, 1'b0, 1'b1, 1'b1, 3'd5, RST_LINE},
		// seq 0 again after reset
		'{ugfe_pkg::CMD_DATA, 8'hFE, 1'b1, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_ACK,  8'h7E, 1'b0, 1'b1, 1'b0, 3'd0, 40'h0},
		// control byte 0x11 must be escaped
		'{ugfe_pkg::CMD_DATA, 8'h3C, 1'b1, 1'b1, 1'b0, 3'd0, 40'h0},
		'{ugfe_pkg::CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1, 3'd0, 40'h0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic line_ready = 1'b0;

	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ugfe_pkg::PADDR_W-1:0]  paddr;
	logic [ugfe_pkg::DATA_W-1:0]   pwdata;
	logic [ugfe_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	ugfe_in_if  req_if ();
	ugfe_out_if tx_if ();

	assign tx_if.ready = line_ready;

	uart_gateway_frame_encoder_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.tx      (tx_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// Predictor state: mirrors the framer between commands.
	logic [15:0] p_crc  = CCITT_SEED;
	logic [7:0]  p_wht  = WHITE_SEED;
	logic [7:0]  p_seq  = 8'h00;
	logic [2:0]  p_ackn = 3'd0;
	logic        p_open = 1'b0;
	logic        p_ext  = 1'b0;

	line_word_t cmd_words [$];       // line words of the command being predicted
	line_word_t due_line_words [$];  // words accepted on req but not yet seen on tx

	int err_cnt = 0;
	int words_seen = 0;
	int frames_closed = 0;
	int cmd_cnt [4] = '{0, 0, 0, 0};
	int cycle_no = 0;

	// Idling knobs, set per phase.
	bit sender_gaps = 1'b1;
	bit recv_stalls = 1'b1;
	int burst_left = 0;

	task automatic flag_error(input string what);
		err_cnt++;
		if (err_cnt <= 40) begin
			$display("[%0t] ERROR: %s", $time, what);
		end
	endtask

	// CRC-CCITT, one bit at a time, MSB first.
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CCITT_POLY;
			end
		end
		return c;
	endfunction

	function automatic void put_word(input logic [7:0] b);
		cmd_words.push_back('{val: b, fin: 1'b0});
	endfunction

	// Reserved line values go out as escape mark plus the flipped byte.
	function automatic void put_escaped(input logic [7:0] b);
		case (b)
			8'h11, 8'h13, 8'h18, 8'h1A, 8'h7D, 8'h7E: begin
				put_word(ESC_MARK);
				put_word(b ^ ESC_FLIP);
			end
			default: begin
				put_word(b);
			end
		endcase
	endfunction

	// Whiten with the LFSR, feed the crc with the whitened value, then escape.
	function automatic void put_whitened(input logic [7:0] b);
		logic [7:0] w;
		w = b ^ p_wht;
		p_wht = p_wht[0] ? ((p_wht >> 1) ^ WHITE_TAPS) : (p_wht >> 1);
		p_crc = crc_step(p_crc, w);
		put_escaped(w);
	endfunction

	// Line words caused by one command; advances the predictor state.
	function automatic void frame_line_bytes(input ugfe_pkg::cmd_t c, input logic [7:0] d,
			input logic l);
		logic [7:0]  ctl;
		logic [15:0] ack_crc;
		cmd_words.delete();
		case (c)
			ugfe_pkg::CMD_DATA: begin
				if (!p_open) begin
					// header: raw control byte into crc, then whitened seq and zero (and 0xFF, zero if extended)
					ctl = {1'b0, p_seq[2:0], 1'b0, p_ackn};
					p_crc = crc_step(CCITT_SEED, ctl);
					p_wht = WHITE_SEED;
					put_escaped(ctl);
					put_whitened(p_seq);
					put_whitened(8'h00);
					if (p_ext) begin
						put_whitened(8'hFF);
						put_whitened(8'h00);
					end
					p_open = 1'b1;
				end
				put_whitened(d);
				if (l) begin
					put_escaped(p_crc[15:8]);
					put_escaped(p_crc[7:0]);
					put_word(LINE_FLAG);
					p_seq = p_seq + 8'd1;
					p_open = 1'b0;
				end
			end
			ugfe_pkg::CMD_ACK: begin
				// ack has its own crc; the data frame crc stays as it is
				p_ackn = p_ackn + 3'd1;
				ctl = ACK_CTRL | {5'd0, p_ackn};
				ack_crc = crc_step(CCITT_SEED, ctl);
				put_word(ctl);
				put_escaped(ack_crc[15:8]);
				put_escaped(ack_crc[7:0]);
				put_word(LINE_FLAG);
			end
			ugfe_pkg::CMD_RST: begin
				for (int i = 0; i < 5; i++) begin
					put_word(RST_LINE[39 - 8*i -: 8]);
				end
				p_crc = CCITT_SEED;
				p_wht = WHITE_SEED;
				p_seq = 8'h00;
				p_ackn = 3'd0;
				p_open = 1'b0;
			end
			default: begin
			end
		endcase
		if (cmd_words.size() > 0) begin
			cmd_words[cmd_words.size() - 1].fin = 1'b1;
		end
	endfunction

	// Offer one command word on req, wait for the handshake, then queue what it
	// must put on the line. Sender idles in bursts: random-length runs, random gaps.
	task automatic issue_command(input ugfe_pkg::cmd_t c, input logic [7:0] d, input logic l,
			input logic typed_in, input logic [2:0] n_typed, input logic [39:0] typed_bytes);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps ? $urandom_range(1, 7) : 0;
		end else begin
			gap = 0;
		end
		burst_left--;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.cmd       <= c;
		req_if.data_byte <= d;
		req_if.last_byte <= l;
		req_if.valid     <= 1'b1;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		// taken at this edge; valid stays high in case the next word follows at once
		frame_line_bytes(c, d, l);
		if (typed_in) begin
			for (int i = 0; i < n_typed; i++) begin
				due_line_words.push_back('{val: typed_bytes[39 - 8*i -: 8],
					fin: (i == n_typed - 1)});
			end
		end else begin
			foreach (cmd_words[i]) begin
				due_line_words.push_back(cmd_words[i]);
			end
		end
		cmd_cnt[c]++;
		if (c == ugfe_pkg::CMD_DATA && l) begin
			frames_closed++;
		end
	endtask

	// Stop sending and let every expected line word come out, plus the latency
	// tail so that an ignored command cannot still be in flight.
	task automatic wait_line_idle();
		req_if.valid <= 1'b0;
		while (due_line_words.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// APB transfer: setup, then access until pready, then back to idle.
	task automatic cfg_access(input logic wr, input logic [ugfe_pkg::PADDR_W-1:0] a,
			input logic [ugfe_pkg::DATA_W-1:0] wd, output logic [ugfe_pkg::DATA_W-1:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Switch header mode with the framer idle, and read the register back.
	task automatic set_header_mode(input logic m);
		logic [ugfe_pkg::DATA_W-1:0] rd;
		wait_line_idle();
		cfg_access(1'b1, ugfe_pkg::ADDR_EXT_HDR, ugfe_pkg::DATA_W'(m), rd);
		cfg_access(1'b0, ugfe_pkg::ADDR_EXT_HDR, '0, rd);
		if (rd !== ugfe_pkg::DATA_W'(m)) begin
			flag_error($sformatf("extended_header reads 0x%08h after writing %0d", rd, m));
		end
		p_ext = m;
	endtask

	// Random commands: mostly well-formed frames with random payload, some acks
	// dropped inside frames, some resets between frames, a little noise.
	task automatic random_phase(input int n_items);
		int sent;
		int flen;
		int r;
		logic [7:0] d;
		logic [7:0] resv;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				// ignored, not counted as stimulus
				issue_command(ugfe_pkg::CMD_NONE, 8'($urandom), 1'($urandom),
					1'b0, 3'd0, 40'h0);
			end else if (r < 7) begin
				issue_command(ugfe_pkg::CMD_RST, 8'($urandom), 1'($urandom),
					1'b0, 3'd0, 40'h0);
				sent++;
			end else if (r < 20) begin
				issue_command(ugfe_pkg::CMD_ACK, 8'($urandom), 1'($urandom),
					1'b0, 3'd0, 40'h0);
				sent++;
			end else begin
				// mostly short frames, now and then a long one
				flen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
				for (int k = 0; k < flen; k++) begin
					if (p_open && $urandom_range(0, 3) == 0) begin
						// pick a payload that whitens onto a reserved line value
						case ($urandom_range(0, 5))
							0: resv = 8'h11;
							1: resv = 8'h13;
							2: resv = 8'h18;
							3: resv = 8'h1A;
							4: resv = 8'h7D;
							default: resv = 8'h7E;
						endcase
						d = resv ^ p_wht;
					end else begin
						d = 8'($urandom);
					end
					issue_command(ugfe_pkg::CMD_DATA, d, (k == flen - 1), 1'b0, 3'd0, 40'h0);
					sent++;
					if (k < flen - 1 && $urandom_range(0, 11) == 0) begin
						issue_command(ugfe_pkg::CMD_ACK, 8'($urandom), 1'($urandom),
							1'b0, 3'd0, 40'h0);
						sent++;
					end
				end
			end
		end
	endtask

	// Line side: check each accepted word against the oldest expectation, then
	// set ready for the next cycle from a rotating stall pattern.
	logic [15:0] stall_pat = 16'hB5C3;
	logic [5:0]  stall_tick = 6'd0;

	always @(posedge clk) begin : line_check
		line_word_t w;
		if (arst_n === 1'b1 && tx_if.valid === 1'b1 && line_ready) begin
			words_seen++;
			if (due_line_words.size() == 0) begin
				flag_error($sformatf("line word 0x%02h arrived with nothing due", tx_if.out_byte));
			end else begin
				w = due_line_words.pop_front();
				if (tx_if.out_byte !== w.val) begin
					flag_error($sformatf("line word %0d: out_byte 0x%02h, expected 0x%02h",
						words_seen, tx_if.out_byte, w.val));
				end
				if (tx_if.run_end !== w.fin) begin
					flag_error($sformatf("line word %0d: run_end %b, expected %b",
						words_seen, tx_if.run_end, w.fin));
				end
			end
		end
		stall_tick <= stall_tick + 6'd1;
		if (stall_tick == 6'd0) begin
			stall_pat <= 16'($urandom) | 16'h0001;  // never an all-stall pattern
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		end
		line_ready <= !recv_stalls || stall_pat[0];
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d line words still due",
				cycle_no, due_line_words.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : main_seq
		logic [ugfe_pkg::DATA_W-1:0] rd;
		arst_n           <= 1'b0;
		req_if.valid     <= 1'b0;
		req_if.cmd       <= ugfe_pkg::CMD_NONE;
		req_if.data_byte <= 8'h00;
		req_if.last_byte <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register comes out of reset cleared
		cfg_access(1'b0, ugfe_pkg::ADDR_EXT_HDR, '0, rd);
		if (rd !== '0) begin
			flag_error($sformatf("extended_header reads 0x%08h after reset", rd));
		end

		// directed table; a change of header mode waits for the line to go idle
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].ext != p_ext) begin
				set_header_mode(DIRECTED[i].ext);
			end
			issue_command(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].fin,
				DIRECTED[i].typed_in, DIRECTED[i].n_typed, DIRECTED[i].typed_bytes);
		end

		// random phases; each starts from a drained line, which also makes the
		// sender hold off until every due word is out
		sender_gaps = 1'b1;
		recv_stalls = 1'b1;
		set_header_mode(1'b0);
		random_phase(PHASE_ITEMS);

		set_header_mode(1'b1);
		random_phase(PHASE_ITEMS);

		// full speed on both sides
		sender_gaps = 1'b0;
		recv_stalls = 1'b0;
		set_header_mode(1'b0);
		random_phase(PHASE_ITEMS);

		sender_gaps = 1'b1;
		set_header_mode(1'b1);
		random_phase(PHASE_ITEMS);

		wait_line_idle();

		$display("Sent %0d payload bytes in %0d closed frames, %0d acks, %0d resets, %0d ignored.",
			cmd_cnt[ugfe_pkg::CMD_DATA], frames_closed, cmd_cnt[ugfe_pkg::CMD_ACK],
			cmd_cnt[ugfe_pkg::CMD_RST], cmd_cnt[ugfe_pkg::CMD_NONE]);
		$display("Checked %0d line words in both header modes, with and without stalls; %0d errors.",
			words_seen, err_cnt);
		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
